### hw/rtl/sf_pkg.sv
package sf_pkg;

   // audio sample as carried on both channels
   typedef logic signed [15:0] sample_type;

   // register map, index = paddr / 4
   typedef enum logic [2:0] {
      REG_DELAY    = 3'd0,
      REG_DEPTH    = 3'd1,
      REG_STEP     = 3'd2,
      REG_OFFSET   = 3'd3,
      REG_DRY      = 3'd4,
      REG_WET      = 3'd5,
      REG_FB_LEFT  = 3'd6,
      REG_FB_RIGHT = 3'd7
   } cfg_reg_type;

   // input beat kinds
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_PHASE = 1'b1;

   // quarter-wave sine polynomial, x in Q16
   localparam int SIN_A = 51472;
   localparam int SIN_B = 21167;
   localparam int SIN_C = 2463;
   localparam int SIN_ONE = 65536;
   localparam int SAMPLE_MAX = 32767;

   localparam sample_type DRY_RESET = 16'sh7FFF;

   // clamp a widened sum to the sample range
   function automatic sample_type sat_sample(input logic signed [32:0] v);
      if (v > 33'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -33'sd32768) begin
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

### hw/rtl/sf_ifs.sv
// input channel: stereo frame or phase set
interface sf_req_if;
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   sf_pkg::sample_type   left_in;
   sf_pkg::sample_type   right_in;
   logic [7:0]           phase_value;

   modport source (output valid, req_type, left_in, right_in, phase_value, input ready);
   modport sink   (input valid, req_type, left_in, right_in, phase_value, output ready);
endinterface

// result channel: processed stereo frame
interface sf_rsp_if;
   logic                 valid;
   logic                 ready;
   sf_pkg::sample_type   left_out;
   sf_pkg::sample_type   right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

### hw/rtl/sf_ram.sv
module sf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/stereo_flanger.sv
// Stereo flanger: sine-modulated delay with feedback, one delay line per channel.
// req_bus takes a beat when valid and ready are high. A frame beat (req_type 0)
// carries left_in/right_in and yields one beat on rsp_bus; a phase beat
// (req_type 1) loads the modulation phase from phase_value and yields
// nothing. Registers are written over the APB port (4 bytes apart).
// Per channel the frame runs four multiplies for the sine (S_X2, S_T, S_U,
// S_S), one for the tap offset (S_OFF), the tap index wrap (S_FIX, adding
// the line length while the index is negative), then the feedback, dry and
// wet products (S_FB, S_DRY, S_WET); all multiplies go through one 23x18
// multiplier. S_PUT hands the result over. One RAM read and one write per
// channel. ready is low while a frame is in work.
// A write to delay_samples or mod_depth runs S_RED1 and S_RED2 to wrap the
// write index to the new line length; frames wait meanwhile.
// Reset is synchronous; no clearing pass runs: a fill mark makes never
// written entries read as zero. If rsp_bus stalls, the finished frame holds
// in the output register; the next frame is accepted and computed, then
// waits in its last state until the output register frees.
module stereo_flanger #(
   parameter int MAX_DELAY       = 8192,
   parameter int LINE_DEPTH      = 16384,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   sf_req_if.sink      req_bus,
   sf_rsp_if.source    rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW  = $clog2(LINE_DEPTH);
   localparam int LW  = $clog2(LINE_DEPTH + 1);
   localparam int HI  = (IW + 1) / 2;
   localparam int RW  = IW + LW;
   localparam int RDW = ((IW > 14) ? IW : 14) + 2;
   localparam int STB = SINE_TABLE_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RED1, S_RED2, S_X2, S_T, S_U, S_S, S_OFF, S_FIX,
      S_FB, S_DRY, S_WET, S_PUT
   } state_type;

   state_type              state_ff, state_in;

   // configuration
   logic [12:0]            delay_ff, delay_in;
   logic [20:0]            depth_ff, depth_in;
   logic [30:0]            step_ff, step_in;
   logic [15:0]            offset_ff, offset_in;
   sf_pkg::sample_type     dry_ff, dry_in, wet_ff, wet_in;
   sf_pkg::sample_type     fbl_ff, fbl_in, fbr_ff, fbr_in;
   logic [12:0]            eff_delay_ff, eff_delay_in;
   logic [20:0]            eff_depth_ff, eff_depth_in;
   logic [LW-1:0]          len_ff, len_in;

   // line state
   logic [IW-1:0]          wr_ff, wr_in;
   logic [LW-1:0]          mark_ff, mark_in;
   logic [31:0]            phase_ff, phase_in;

   // datapath
   logic                   ch_ff, ch_in;
   logic [16:0]            xq_ff, xq_in;
   logic                   neg_ff, neg_in;
   logic [16:0]            x2_ff, x2_in;
   logic [15:0]            t_ff, t_in, u_ff, u_in;
   sf_pkg::sample_type     sin_ff, sin_in;
   logic signed [RDW-1:0]  rd_ff, rd_in;
   sf_pkg::sample_type     tap_ff, tap_in;
   logic signed [31:0]     acc_ff, acc_in;
   sf_pkg::sample_type     inl_ff, inl_in, inr_ff, inr_in;
   sf_pkg::sample_type     outl_ff, outl_in, outr_ff, outr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sf_pkg::sample_type     rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;

   // shared multiplier
   logic signed [22:0]     mul_a;
   logic signed [17:0]     mul_b;
   logic signed [40:0]     mul_p;

   // combinational helpers
   logic                   cfg_wen, len_write;
   sf_pkg::cfg_reg_type    cfg_idx;
   logic [31:0]            ed32, len32;
   logic [20:0]            dep_lim, edep;
   logic [RW-1:0]          lenw, rem_hi, rem_lo;
   logic [31:0]            cur_phase;
   logic [STB-1:0]         sin_idx;
   logic [15:0]            xr;
   logic [16:0]            xq_c;
   logic [16:0]            s17;
   logic [14:0]            s15;
   sf_pkg::sample_type     in_c, fb_c, tap_c, wv, y;
   logic signed [32:0]     sum33;
   logic [LW-1:0]          wr_inc;
   logic                   wen_l, wen_r;
   logic [15:0]            rdata_l, rdata_r;

   assign pready  = 1'b1;
   assign cfg_wen = psel && penable && pwrite;
   assign cfg_idx = sf_pkg::cfg_reg_type'(paddr[4:2]);
   assign mul_p   = mul_a * mul_b;
   assign req_bus.ready = (state_ff == S_IDLE);

   // register read back
   always_comb begin
      unique case (cfg_idx)
         sf_pkg::REG_DELAY:    prdata = {19'd0, delay_ff};
         sf_pkg::REG_DEPTH:    prdata = {11'd0, depth_ff};
         sf_pkg::REG_STEP:     prdata = {1'b0, step_ff};
         sf_pkg::REG_OFFSET:   prdata = {16'd0, offset_ff};
         sf_pkg::REG_DRY:      prdata = {16'd0, dry_ff};
         sf_pkg::REG_WET:      prdata = {16'd0, wet_ff};
         sf_pkg::REG_FB_LEFT:  prdata = {16'd0, fbl_ff};
         sf_pkg::REG_FB_RIGHT: prdata = {16'd0, fbr_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // register writes and derived line length
   always_comb begin
      delay_in  = delay_ff;
      depth_in  = depth_ff;
      step_in   = step_ff;
      offset_in = offset_ff;
      dry_in    = dry_ff;
      wet_in    = wet_ff;
      fbl_in    = fbl_ff;
      fbr_in    = fbr_ff;
      if (cfg_wen) begin
         unique case (cfg_idx)
            sf_pkg::REG_DELAY:    delay_in  = pwdata[12:0];
            sf_pkg::REG_DEPTH:    depth_in  = pwdata[20:0];
            sf_pkg::REG_STEP:     step_in   = pwdata[30:0];
            sf_pkg::REG_OFFSET:   offset_in = pwdata[15:0];
            sf_pkg::REG_DRY:      dry_in    = pwdata[15:0];
            sf_pkg::REG_WET:      wet_in    = pwdata[15:0];
            sf_pkg::REG_FB_LEFT:  fbl_in    = pwdata[15:0];
            sf_pkg::REG_FB_RIGHT: fbr_in    = pwdata[15:0];
            default: ;
         endcase
      end
      len_write = cfg_wen && ((cfg_idx == sf_pkg::REG_DELAY) ||
                              (cfg_idx == sf_pkg::REG_DEPTH));
      ed32 = {19'd0, delay_in};
      if (ed32 > 32'(MAX_DELAY - 1)) begin
         ed32 = 32'(MAX_DELAY - 1);
      end
      dep_lim = {ed32[12:0], 8'd0};
      edep    = (depth_in < dep_lim) ? depth_in : dep_lim;
      len32   = 32'd1 + ed32 + 32'((22'(edep) + 22'd255) >> 8);
      if (len32 > 32'(LINE_DEPTH)) begin
         len32 = 32'(LINE_DEPTH);
      end
      eff_delay_in = ed32[12:0];
      eff_depth_in = edep;
   end

   // write index wrap to a new length, in two passes of restoring steps
   always_comb begin
      lenw   = RW'(len_ff);
      rem_hi = RW'(wr_ff);
      for (int k = IW - 1; k >= IW - HI; k--) begin
         if (rem_hi >= (lenw << k)) begin
            rem_hi = rem_hi - (lenw << k);
         end
      end
      rem_lo = RW'(wr_ff);
      for (int k = IW - HI - 1; k >= 0; k--) begin
         if (rem_lo >= (lenw << k)) begin
            rem_lo = rem_lo - (lenw << k);
         end
      end
   end

   // sine point for the current channel
   always_comb begin
      cur_phase = phase_ff + (ch_ff ? {offset_ff, 16'd0} : 32'd0);
      sin_idx   = cur_phase[31 -: STB];
      xr        = 16'(sin_idx[STB-3:0]) << (18 - STB);
      xq_c      = sin_idx[STB-4+2] ? (17'(sf_pkg::SIN_ONE) - {1'b0, xr}) : {1'b0, xr};
   end

   // channel selects, tap masking and saturation
   always_comb begin
      in_c  = ch_ff ? inr_ff : inl_ff;
      fb_c  = ch_ff ? fbr_ff : fbl_ff;
      tap_c = ch_ff ? rdata_r : rdata_l;
      if (LW'(rd_ff[IW-1:0]) >= mark_ff) begin
         tap_c = '0;
      end
      s17 = mul_p[32:16];
      s15 = (s17 > 17'(sf_pkg::SAMPLE_MAX)) ? 15'h7FFF : s17[14:0];
      if (state_ff == S_FB) begin
         sum33 = 33'($signed({in_c, 15'd0})) + 33'($signed(mul_p[31:0]));
      end else begin
         sum33 = 33'(acc_ff) + 33'($signed(mul_p[31:0]));
      end
      wv     = sf_pkg::sat_sample(sum33 >>> 15);
      y      = wv;
      wr_inc = LW'(wr_ff) + LW'(1);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_X2: begin
            mul_a = {6'd0, xq_c};
            mul_b = {1'b0, xq_c};
         end
         S_T: begin
            mul_a = 23'(sf_pkg::SIN_C);
            mul_b = {1'b0, x2_ff};
         end
         S_U: begin
            mul_a = {7'd0, t_ff};
            mul_b = {1'b0, x2_ff};
         end
         S_S: begin
            mul_a = {7'd0, u_ff};
            mul_b = {1'b0, xq_ff};
         end
         S_OFF: begin
            mul_a = {2'd0, eff_depth_ff};
            mul_b = {{2{sin_ff[15]}}, sin_ff};
         end
         S_FB: begin
            mul_a = {{7{fb_c[15]}}, fb_c};
            mul_b = {{2{tap_c[15]}}, tap_c};
         end
         S_DRY: begin
            mul_a = {{7{dry_ff[15]}}, dry_ff};
            mul_b = {{2{in_c[15]}}, in_c};
         end
         S_WET: begin
            mul_a = {{7{wet_ff[15]}}, wet_ff};
            mul_b = {{2{tap_ff[15]}}, tap_ff};
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      wr_in        = wr_ff;
      mark_in      = mark_ff;
      phase_in     = phase_ff;
      ch_in        = ch_ff;
      xq_in        = xq_ff;
      neg_in       = neg_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      sin_in       = sin_ff;
      rd_in        = rd_ff;
      tap_in       = tap_ff;
      acc_in       = acc_ff;
      inl_in       = inl_ff;
      inr_in       = inr_ff;
      outl_in      = outl_ff;
      outr_in      = outr_ff;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      wen_l        = 1'b0;
      wen_r        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.req_type == sf_pkg::REQ_PHASE) begin
                  phase_in = {req_bus.phase_value, 24'd0};
               end else begin
                  inl_in   = req_bus.left_in;
                  inr_in   = req_bus.right_in;
                  ch_in    = 1'b0;
                  state_in = S_X2;
               end
            end
         end
         S_RED1: begin
            wr_in    = rem_hi[IW-1:0];
            state_in = S_RED2;
         end
         S_RED2: begin
            wr_in    = rem_lo[IW-1:0];
            state_in = S_IDLE;
         end
         S_X2: begin
            xq_in    = xq_c;
            neg_in   = sin_idx[STB-1];
            x2_in    = mul_p[32:16];
            state_in = S_T;
         end
         S_T: begin
            t_in     = 16'(sf_pkg::SIN_B) - mul_p[31:16];
            state_in = S_U;
         end
         S_U: begin
            u_in     = 16'(sf_pkg::SIN_A) - mul_p[31:16];
            state_in = S_S;
         end
         S_S: begin
            sin_in   = neg_ff ? -$signed({1'b0, s15}) : $signed({1'b0, s15});
            state_in = S_OFF;
         end
         S_OFF: begin
            rd_in    = $signed(RDW'(wr_ff)) - $signed(RDW'(eff_delay_ff)) +
                       RDW'(mul_p >>> 23);
            state_in = S_FIX;
         end
         S_FIX: begin
            // wrap a negative tap index back into the line
            if (rd_ff < 0) begin
               rd_in = rd_ff + $signed(RDW'(len_ff));
            end else begin
               state_in = S_FB;
            end
         end
         S_FB: begin
            tap_in   = tap_c;
            wen_l    = !ch_ff;
            wen_r    = ch_ff;
            state_in = S_DRY;
         end
         S_DRY: begin
            acc_in   = mul_p[31:0];
            state_in = S_WET;
         end
         S_WET: begin
            if (!ch_ff) begin
               outl_in  = y;
               ch_in    = 1'b1;
               state_in = S_X2;
            end else begin
               outr_in  = y;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_l_in     = outl_ff;
               rsp_r_in     = outr_ff;
               rsp_valid_in = 1'b1;
               wr_in        = (wr_inc == len_ff) ? '0 : wr_inc[IW-1:0];
               if (LW'(wr_ff) == mark_ff) begin
                  mark_in = wr_inc;
               end
               phase_in     = phase_ff + {1'b0, step_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // new line length: wrap the write index, pull the fill mark down
      if (len_write) begin
         len_in   = len32[LW-1:0];
         if (len32[LW-1:0] < mark_in) begin
            mark_in = len32[LW-1:0];
         end
         state_in = S_RED1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         delay_ff     <= '0;
         depth_ff     <= '0;
         step_ff      <= '0;
         offset_ff    <= '0;
         dry_ff       <= sf_pkg::DRY_RESET;
         wet_ff       <= '0;
         fbl_ff       <= '0;
         fbr_ff       <= '0;
         eff_delay_ff <= '0;
         eff_depth_ff <= '0;
         len_ff       <= LW'(1);
         wr_ff        <= '0;
         mark_ff      <= '0;
         phase_ff     <= '0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         depth_ff     <= depth_in;
         step_ff      <= step_in;
         offset_ff    <= offset_in;
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
         fbl_ff       <= fbl_in;
         fbr_ff       <= fbr_in;
         if (len_write) begin
            eff_delay_ff <= eff_delay_in;
            eff_depth_ff <= eff_depth_in;
         end
         len_ff       <= len_in;
         wr_ff        <= wr_in;
         mark_ff      <= mark_in;
         phase_ff     <= phase_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xq_ff    <= xq_in;
      neg_ff   <= neg_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      sin_ff   <= sin_in;
      rd_ff    <= rd_in;
      tap_ff   <= tap_in;
      acc_ff   <= acc_in;
      inl_ff   <= inl_in;
      inr_ff   <= inr_in;
      outl_ff  <= outl_in;
      outr_ff  <= outr_in;
      rsp_l_ff <= rsp_l_in;
      rsp_r_ff <= rsp_r_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = rsp_l_ff;
   assign rsp_bus.right_out = rsp_r_ff;

   // delay lines
   sf_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_left_line (
      .clock   (clock),
      .wr_en   (wen_l),
      .wr_addr (wr_ff),
      .wr_data (wv),
      .rd_addr (rd_ff[IW-1:0]),
      .rd_data (rdata_l)
   );

   sf_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_right_line (
      .clock   (clock),
      .wr_en   (wen_r),
      .wr_addr (wr_ff),
      .wr_data (wv),
      .rd_addr (rd_ff[IW-1:0]),
      .rd_data (rdata_r)
   );

   // write index stays inside the line between frames
   a_wr_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (LW'(wr_ff) < len_ff))
      else $error("write index outside line");

   // fill mark never passes the line length
   a_mark_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (mark_ff <= len_ff))
      else $error("fill mark beyond line length");

   // tap read address is wrapped before the data is used
   a_tap_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FB) |-> (rd_ff >= 0 && rd_ff < $signed(RDW'(len_ff))))
      else $error("tap index outside line");

   // a result appears only out of the hand-over state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_PUT))
      else $error("result without finished frame");

endmodule
